// ===== rtl/bpra_pkg.sv =====
// ----------------------------------------------------------------------------
// bpra_pkg
// Shared types and constants for the bitmap page run allocator.
// ----------------------------------------------------------------------------
package bpra_pkg;

  localparam int WORD_BITS     = 64;                  // bitmap bits per memory word
  localparam int BIT_W         = $clog2(WORD_BITS);
  localparam int CNT_W         = 13;                  // page_count width
  localparam int ADDR_W        = 32;
  localparam int STAT_W        = 2;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 32;
  localparam int MAX_RUN_PAGES = 3840;                // allocations at or above are rejected

  typedef logic [CNT_W-1:0]     count_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [STAT_W-1:0]    status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [WORD_BITS-1:0] word_t;

  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_NOFIT   = 2'd1;
  localparam status_t ST_INVALID = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam cfg_idx_t CFG_POOL_BASE  = 1'b0;
  localparam cfg_idx_t CFG_POOL_PAGES = 1'b1;

  localparam count_t POOL_PAGES_RST = 13'd4096;

  // Result of evaluating one bitmap word during the first-fit search.
  typedef struct packed {
    logic             hit;      // run of the requested length ends in this word
    logic [BIT_W-1:0] pos;      // bit where the run ends
    count_t           run_out;  // free run length carried into the next word
  } scan_res_t;

endpackage

// ===== rtl/bpra_chan_ifs.sv =====
// ----------------------------------------------------------------------------
// bpra_req_if / bpra_rsp_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface bpra_req_if;
  logic              valid;
  logic              ready;
  logic              cmd;
  bpra_pkg::count_t  page_count;
  bpra_pkg::addr_t   address;

  modport source(output valid, cmd, page_count, address, input ready);
  modport sink(input valid, cmd, page_count, address, output ready);
endinterface

interface bpra_rsp_if;
  logic              valid;
  logic              ready;
  bpra_pkg::status_t status;
  bpra_pkg::addr_t   run_address;

  modport source(output valid, status, run_address, input ready);
  modport sink(input valid, status, run_address, output ready);
endinterface

// ===== rtl/bpra_bitmap_ram.sv =====
// ----------------------------------------------------------------------------
// bpra_bitmap_ram
// Occupancy bitmap store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bpra_bitmap_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output bpra_pkg::word_t     rd_data,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  bpra_pkg::word_t     wr_data
);

  bpra_pkg::word_t mem [DEPTH];
  bpra_pkg::word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/bpra_word_scan.sv =====
// ----------------------------------------------------------------------------
// bpra_word_scan
// First-fit evaluation of one bitmap word: free run length at every bit,
// lowest bit where the run reaches the requested count.
// ----------------------------------------------------------------------------
module bpra_word_scan #(
  parameter int PW = 13
) (
  input  bpra_pkg::word_t    word_i,
  input  logic [PW-1:0]      base_i,    // page index of bit 0, word aligned
  input  logic [PW-1:0]      n_i,       // pages in the pool
  input  bpra_pkg::count_t   run_in_i,  // free run ending just below this word
  input  bpra_pkg::count_t   count_i,
  output bpra_pkg::scan_res_t res_o
);

  localparam int WB   = bpra_pkg::WORD_BITS;
  localparam int BW   = bpra_pkg::BIT_W;
  localparam int LU_W = BW + 1;

  // lu[k][j]: 1 + position of the latest used bit among the 2**k bits ending at j, 0 if none
  logic [LU_W-1:0]      lu [BW+1][WB];
  bpra_pkg::count_t     run [WB];
  logic [WB-1:0]        hit_vec;
  logic [PW-1:0]        page;

  always_comb begin
    for (int j = 0; j < WB; j++) begin
      lu[0][j] = word_i[j] ? LU_W'(j + 1) : '0;
    end
    for (int k = 0; k < BW; k++) begin
      for (int j = 0; j < WB; j++) begin
        if ((lu[k][j] == '0) && (j >= (1 << k))) begin
          lu[k+1][j] = lu[k][j - (1 << k)];
        end else begin
          lu[k+1][j] = lu[k][j];
        end
      end
    end
  end

  always_comb begin
    page = '0;
    for (int j = 0; j < WB; j++) begin
      if (lu[BW][j] == '0) begin
        run[j] = run_in_i + bpra_pkg::CNT_W'(j + 1);
      end else begin
        run[j] = bpra_pkg::CNT_W'(j + 1) - bpra_pkg::CNT_W'(lu[BW][j]);
      end
      page       = {base_i[PW-1:BW], BW'(j)};
      hit_vec[j] = (page < n_i) && (run[j] >= count_i);
    end
  end

  always_comb begin
    res_o.hit     = |hit_vec;
    res_o.pos     = '0;
    res_o.run_out = run[WB-1];
    for (int j = WB - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        res_o.pos = BW'(j);
      end
    end
  end

endmodule

// ===== rtl/bitmap_page_run_allocator_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_run_allocator_top
// First-fit page run allocator over a one-bit-per-page occupancy bitmap.
// ----------------------------------------------------------------------------
// Steps: a request is taken in idle and checked; a rejected one goes to the result.
//   An allocate scans from word 0, one 64-bit bitmap word read a cycle, until the run
//   is found or the pool ends; each word of a found or freed run is read and written
//   back, the result is registered onto out_ch, and only one request is in flight.
// Reset: rst_n (sync, active low) clears control state; a clearing pass then zeroes
//   every bitmap word (ceil(MAX_PAGES/64) words, 64 default), in_ch.ready low.
// ----------------------------------------------------------------------------
module bitmap_page_run_allocator_top #(
  parameter int MAX_PAGES  = 4096,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  bpra_req_if.sink                     in_ch,
  bpra_rsp_if.source                   out_ch,
  input  logic                         cfg_we,
  input  bpra_pkg::cfg_idx_t           cfg_index,
  input  logic [bpra_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int WB         = bpra_pkg::WORD_BITS;
  localparam int BW         = bpra_pkg::BIT_W;
  localparam int CW         = bpra_pkg::CNT_W;
  localparam int AD_W       = bpra_pkg::ADDR_W;
  localparam int NWORDS     = (MAX_PAGES + WB - 1) / WB;
  localparam int WA_W       = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int PW         = WA_W + BW + 1;              // page index incl. pool size
  localparam int AW         = ((PW > CW) ? PW : CW) + 1;  // room for a sign bit
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  // FSM codes
  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_CHECK   = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_MARK_RD = 3'd4;
  localparam logic [2:0] S_MARK_WR = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]             state_r, state_nxt;
  logic [WA_W-1:0]        clr_w_r, clr_w_nxt;     // clearing pass word
  logic [WA_W-1:0]        dw_r, dw_nxt;           // word being scanned
  logic [WA_W-1:0]        mw_r, mw_nxt;           // word being marked/cleared
  bpra_pkg::count_t       run_in_r, run_in_nxt;
  logic [PW-1:0]          lo_r, lo_nxt;           // first page of the run
  logic [PW-1:0]          last_r, last_nxt;       // last page of the run
  logic                   req_cmd_r, req_cmd_nxt;
  bpra_pkg::count_t       req_count_r, req_count_nxt;
  bpra_pkg::addr_t        req_addr_r, req_addr_nxt;
  bpra_pkg::status_t      res_status_r, res_status_nxt;
  bpra_pkg::addr_t        res_addr_r, res_addr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  bpra_pkg::status_t      out_status_r, out_status_nxt;
  bpra_pkg::addr_t        out_addr_r, out_addr_nxt;
  bpra_pkg::addr_t        pool_base_r, pool_base_nxt;
  bpra_pkg::count_t       pool_pages_r, pool_pages_nxt;

  // bitmap memory port
  logic                   rd_en;
  logic [WA_W-1:0]        rd_addr;
  bpra_pkg::word_t        rd_data;
  logic                   wr_en;
  logic [WA_W-1:0]        wr_addr;
  bpra_pkg::word_t        wr_data;

  // datapath helpers
  logic [PW-1:0]          n_pages;
  logic [PW-1:0]          scan_base;
  logic [PW-1:0]          next_base;
  logic                   scan_last;
  bpra_pkg::scan_res_t    scan_res;
  logic [PW-2:0]          hit_page;
  logic [PW-1:0]          hit_lo;                 // first page of a found run
  logic [AD_W:0]          off;
  logic [AD_W-PAGE_SHIFT-1:0] idx;
  logic [PW-1:0]          free_lo;                // first page of a run to free
  logic [AW-1:0]          lim;
  logic                   free_ok;
  logic                   alloc_ok;
  logic [PW+PAGE_SHIFT-1:0] run_off;
  logic [WA_W-1:0]        lo_w;
  logic [WA_W-1:0]        last_w;
  bpra_pkg::word_t        mask;

  bpra_bitmap_ram #(
    .DEPTH  (NWORDS),
    .ADDR_W (WA_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bpra_word_scan #(
    .PW (PW)
  ) u_scan (
    .word_i   (rd_data),
    .base_i   (scan_base),
    .n_i      (n_pages),
    .run_in_i (run_in_r),
    .count_i  (req_count_r),
    .res_o    (scan_res)
  );

  // effective pool size = min(pool_pages, MAX_PAGES)
  assign n_pages = (AW'(pool_pages_r) < AW'(MAX_PAGES)) ? PW'(pool_pages_r)
                                                        : PW'(MAX_PAGES);

  assign scan_base = PW'({dw_r, BW'(0)});
  assign next_base = scan_base + PW'(WB);
  assign scan_last = (next_base >= n_pages);
  assign hit_page  = {dw_r, scan_res.pos};
  assign hit_lo    = PW'(AW'(hit_page) + AW'(1) - AW'(req_count_r));

  // free request checks: nonzero count, below base, alignment, run inside the pool
  assign off      = {1'b0, req_addr_r} - {1'b0, pool_base_r};
  assign idx      = off[AD_W-1:PAGE_SHIFT];
  assign free_lo  = PW'(idx);
  assign lim      = AW'(n_pages) - AW'(req_count_r);
  assign free_ok  = (req_count_r != '0) && !off[AD_W]
                    && (off[PAGE_SHIFT-1:0] == '0) && !lim[AW-1]
                    && (AD_W'(idx) <= AD_W'(lim));
  assign alloc_ok = (req_count_r != '0)
                    && (req_count_r < CW'(bpra_pkg::MAX_RUN_PAGES));

  assign run_off = {lo_r, {PAGE_SHIFT{1'b0}}};
  assign lo_w    = lo_r[PW-2:BW];
  assign last_w  = last_r[PW-2:BW];

  always_comb begin
    for (int j = 0; j < WB; j++) begin
      mask[j] = ((mw_r != lo_w) || (BW'(j) >= lo_r[BW-1:0]))
                && ((mw_r != last_w) || (BW'(j) <= last_r[BW-1:0]));
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.run_address = out_addr_r;

  always_comb begin
    state_nxt      = state_r;
    clr_w_nxt      = clr_w_r;
    dw_nxt         = dw_r;
    mw_nxt         = mw_r;
    run_in_nxt     = run_in_r;
    lo_nxt         = lo_r;
    last_nxt       = last_r;
    req_cmd_nxt    = req_cmd_r;
    req_count_nxt  = req_count_r;
    req_addr_nxt   = req_addr_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    pool_base_nxt  = pool_base_r;
    pool_pages_nxt = pool_pages_r;
    rd_en          = 1'b0;
    rd_addr        = dw_r;
    wr_en          = 1'b0;
    wr_addr        = mw_r;
    wr_data        = (req_cmd_r == bpra_pkg::CMD_ALLOC) ? (rd_data | mask)
                                                        : (rd_data & ~mask);

    if (cfg_we) begin
      unique case (cfg_index)
        bpra_pkg::CFG_POOL_BASE:  pool_base_nxt  = cfg_wdata[AD_W-1:0];
        bpra_pkg::CFG_POOL_PAGES: pool_pages_nxt = cfg_wdata[CW-1:0];
      endcase
    end

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_w_r;
        wr_data = '0;
        clr_w_nxt = clr_w_r + 1'b1;
        if (clr_w_r == WA_W'(NWORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          req_cmd_nxt   = in_ch.cmd;
          req_count_nxt = in_ch.page_count;
          req_addr_nxt  = in_ch.address;
          state_nxt     = S_CHECK;
        end
      end

      S_CHECK: begin
        res_addr_nxt   = '0;
        res_status_nxt = bpra_pkg::ST_INVALID;
        state_nxt      = S_DONE;
        if (req_cmd_r == bpra_pkg::CMD_ALLOC) begin
          if (alloc_ok) begin
            // prefetch word 0; scan starts next cycle
            rd_en      = 1'b1;
            rd_addr    = '0;
            dw_nxt     = '0;
            run_in_nxt = '0;
            state_nxt  = S_SCAN;
          end
        end else if (free_ok) begin
          lo_nxt         = free_lo;
          last_nxt       = PW'(AW'(free_lo) + AW'(req_count_r) - AW'(1));
          mw_nxt         = free_lo[PW-2:BW];
          res_status_nxt = bpra_pkg::ST_DONE;
          state_nxt      = S_MARK_RD;
        end
      end

      S_SCAN: begin
        if (scan_res.hit) begin
          lo_nxt         = hit_lo;
          last_nxt       = PW'(hit_page);
          mw_nxt         = hit_lo[PW-2:BW];
          res_status_nxt = bpra_pkg::ST_DONE;
          state_nxt      = S_MARK_RD;
        end else if (scan_last) begin
          res_status_nxt = bpra_pkg::ST_NOFIT;
          state_nxt      = S_DONE;
        end else begin
          // next word is inside the memory whenever this is not the last one
          rd_en      = 1'b1;
          rd_addr    = dw_r + 1'b1;
          dw_nxt     = dw_r + 1'b1;
          run_in_nxt = scan_res.run_out;
        end
      end

      S_MARK_RD: begin
        rd_en   = 1'b1;
        rd_addr = mw_r;
        if (req_cmd_r == bpra_pkg::CMD_ALLOC) begin
          res_addr_nxt = pool_base_r + AD_W'(run_off);
        end
        state_nxt = S_MARK_WR;
      end

      S_MARK_WR: begin
        wr_en   = 1'b1;
        wr_addr = mw_r;
        mw_nxt  = mw_r + 1'b1;
        if (mw_r == last_w) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MARK_RD;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_w_r      <= '0;
      out_valid_r  <= 1'b0;
      pool_base_r  <= '0;
      pool_pages_r <= bpra_pkg::POOL_PAGES_RST;
    end else begin
      state_r      <= state_nxt;
      clr_w_r      <= clr_w_nxt;
      out_valid_r  <= out_valid_nxt;
      pool_base_r  <= pool_base_nxt;
      pool_pages_r <= pool_pages_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    dw_r         <= dw_nxt;
    mw_r         <= mw_nxt;
    run_in_r     <= run_in_nxt;
    lo_r         <= lo_nxt;
    last_r       <= last_nxt;
    req_cmd_r    <= req_cmd_nxt;
    req_count_r  <= req_count_nxt;
    req_addr_r   <= req_addr_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

endmodule
